@@ hdl/pal_pkg.sv @@
package pal_pkg;

  // Fixed field widths of the command and result ports
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned OFF_W    = 12;
  localparam int unsigned IDX_O_W  = 11;
  localparam int unsigned CNT_O_W  = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LG_W     = 4;

  // Block size register reset: 8-byte blocks
  localparam logic [LG_W-1:0] LG_RESET = 4'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIME,
    S_EVAL
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch command, set first row address
    logic step;    // advance row read address
    logic eval;    // row data on the read port belongs to this item
    logic finish;  // commit updates and register the result
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic last;    // current row ends the command
  } stat_t;

endpackage

@@ hdl/page_block_allocator_top.sv @@
// Channel   Direction  Signals                                     Handshake
// command   in         cmd, free_offset                            start && !busy
// result    out        status, block_offset, blk_index,            done, one cycle
//                      empty_count
// config    in         cfg_wdata                                   cfg_we
//
// An item keeps busy high through a prime state, then one evaluation per bitmap
// row examined (64 flags a row, 16 if BLOCK_CAP is below 64): free examines one
// row; allocate walks from the hint's row until a row holds an empty block or
// the last block's row is reached; count walks every row in use. The result
// strobe is high in the first cycle with busy low; a new item waits for busy low.
// The bitmap memory, read one row per cycle, sets how long an item takes.
// Reset is synchronous; per-row valid bits make the bitmap read as all empty
// at once. The receiver cannot stall, so results never wait.
module page_block_allocator_top import pal_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 64,
  parameter int unsigned BLOCK_CAP    = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [OFF_W-1:0]    free_offset,
  input  logic                cfg_we,
  input  logic [LG_W-1:0]     cfg_wdata,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [OFF_W-1:0]    block_offset,
  output logic [IDX_O_W-1:0]  blk_index,
  output logic [CNT_O_W-1:0]  empty_count
);

  ctl_t  ctl;
  stat_t stat;

  // Sequencer
  pal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .stat  (stat)
  );

  // Bitmap, hint and result registers
  pal_datapath #(
    .PAGE_BYTES   (PAGE_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .BLOCK_CAP    (BLOCK_CAP)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .cmd          (cmd),
    .free_offset  (free_offset),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .status       (status),
    .block_offset (block_offset),
    .blk_index    (blk_index),
    .empty_count  (empty_count)
  );

endmodule

@@ hdl/pal_ctrl.sv @@
module pal_ctrl import pal_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output ctl_t  ctl,
  input  stat_t stat
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_PRIME;
        end
      end
      S_PRIME: begin
        // first row read is in flight
        ctl.step   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        ctl.step = 1'b1;
        ctl.eval = 1'b1;
        if (stat.last) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // An accepted item always holds the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

endmodule

@@ hdl/pal_datapath.sv @@
module pal_datapath import pal_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 64,
  parameter int unsigned BLOCK_CAP    = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  ctl_t                ctl,
  output stat_t               stat,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [OFF_W-1:0]    free_offset,
  input  logic                cfg_we,
  input  logic [LG_W-1:0]     cfg_wdata,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [OFF_W-1:0]    block_offset,
  output logic [IDX_O_W-1:0]  blk_index,
  output logic [CNT_O_W-1:0]  empty_count
);

  // Bitmap geometry: W flags per memory row
  localparam int unsigned W     = (BLOCK_CAP >= 64) ? 64 : 16;
  localparam int unsigned WLOG  = $clog2(W);
  localparam int unsigned ROWS  = (BLOCK_CAP + W - 1) / W;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned IDX_W = ROW_W + WLOG;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned PA_W  = $clog2(PAGE_BYTES) + 1;
  localparam int unsigned AW    = (PA_W > CNT_W) ? PA_W : CNT_W;
  localparam int unsigned AREA  = PAGE_BYTES - HEADER_BYTES;

  // Raw block count per size code: area / (size + 1 flag byte)
  function automatic int unsigned raw_blocks(input logic [LG_W-1:0] code);
    case (code)
      4'd0:    return AREA / 2;
      4'd1:    return AREA / 3;
      4'd2:    return AREA / 5;
      4'd3:    return AREA / 9;
      4'd4:    return AREA / 17;
      4'd5:    return AREA / 33;
      4'd6:    return AREA / 65;
      4'd7:    return AREA / 129;
      4'd8:    return AREA / 257;
      4'd9:    return AREA / 513;
      4'd10:   return AREA / 1025;
      4'd11:   return AREA / 2049;
      4'd12:   return AREA / 4097;
      4'd13:   return AREA / 8193;
      4'd14:   return AREA / 16385;
      default: return AREA / 32769;
    endcase
  endfunction

  localparam int unsigned N_RESET =
    (raw_blocks(LG_RESET) > BLOCK_CAP) ? BLOCK_CAP : raw_blocks(LG_RESET);

  // Configuration and allocator state
  logic [LG_W-1:0]  lg;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] n_next;
  logic [IDX_W-1:0] hint;

  // Per-item registers
  cmd_t             cmd_q;
  logic [IDX_W-1:0] free_idx;
  logic             free_bad;
  logic [CNT_W-1:0] cnt_acc;
  logic [IDX_W-1:0] last_acc;
  logic             has_acc;

  // Bitmap memory and read pipeline
  logic [W-1:0]     mem [ROWS];
  logic [ROWS-1:0]  row_valid;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] ev_row;
  logic [W-1:0]     rdata;
  logic             rvalid_q;
  logic             wr_en;
  logic [W-1:0]     wr_data;

  // Load-time free decode
  logic [AW-1:0]    base;
  logic [AW-1:0]    off_ext;
  logic [AW-1:0]    diff;
  logic [AW-1:0]    idx_full;
  logic             below;
  logic             bad_in;
  logic [ROW_W-1:0] first_row;

  // Row evaluation
  logic [W-1:0]      row_data;
  logic [ROW_W:0]    nrow;
  logic [WLOG-1:0]   nlow;
  logic [W-1:0]      nmask;
  logic [W-1:0]      hmask;
  logic [W-1:0]      empty;
  logic [W-1:0]      cand;
  logic [W-1:0]      low_iso;
  logic [W-1:0]      empty_rev;
  logic [W-1:0]      hi_iso;
  logic [WLOG-1:0]   low_pos;
  logic [WLOG-1:0]   hi_rpos;
  logic              any_cand;
  logic              any_empty;
  logic [IDX_W-1:0]  found;
  logic [IDX_W-1:0]  hi_idx;
  logic              row_last;
  logic [CNT_W-1:0]  pop;
  logic [CNT_W-1:0]  found_next;
  logic [AW-1:0]     alloc_off;
  logic              free_bit;
  logic [CNT_W-1:0]  cnt_total;
  logic [IDX_W-1:0]  last_total;
  logic              has_total;

  // Block count follows the size code
  always_comb begin
    int unsigned raw;
    raw    = raw_blocks(cfg_wdata);
    n_next = (raw > BLOCK_CAP) ? CNT_W'(BLOCK_CAP) : CNT_W'(raw);
  end

  // Free offset to index: subtract data start, shift by size
  always_comb begin
    base      = AW'(HEADER_BYTES) + AW'(n);
    off_ext   = AW'(free_offset);
    below     = (off_ext < base);
    diff      = off_ext - base;
    idx_full  = diff >> lg;
    bad_in    = below || (idx_full >= AW'(n));
    case (cmd_t'(cmd))
      CMD_ALLOC: first_row = hint[IDX_W-1:WLOG];
      CMD_FREE:  first_row = idx_full[IDX_W-1:WLOG];
      default:   first_row = '0;
    endcase
  end

  // Row masks, find-first searches and popcount
  always_comb begin
    row_data = rvalid_q ? rdata : '0;
    nrow     = n[CNT_W-1:WLOG];
    nlow     = n[WLOG-1:0];
    if ({1'b0, ev_row} < nrow) begin
      nmask = '1;
    end else if ({1'b0, ev_row} == nrow) begin
      nmask = ~({W{1'b1}} << nlow);
    end else begin
      nmask = '0;
    end
    // scan starts in the hint's row, so only that row is cut
    hmask = (ev_row == hint[IDX_W-1:WLOG]) ? ({W{1'b1}} << hint[WLOG-1:0]) : '1;
    empty = ~row_data & nmask;
    cand  = empty & hmask;
    for (int k = 0; k < W; k++) begin
      empty_rev[k] = empty[W-1-k];
    end
    low_iso = cand & (~cand + W'(1));
    hi_iso  = empty_rev & (~empty_rev + W'(1));
    // one-hot to binary
    for (int b = 0; b < WLOG; b++) begin
      low_pos[b] = 1'b0;
      hi_rpos[b] = 1'b0;
      for (int k = 0; k < W; k++) begin
        if (((k >> b) & 1) == 1) begin
          low_pos[b] = low_pos[b] | low_iso[k];
          hi_rpos[b] = hi_rpos[b] | hi_iso[k];
        end
      end
    end
    any_cand   = |cand;
    any_empty  = |empty;
    found      = {ev_row, low_pos};
    hi_idx     = {ev_row, ~hi_rpos};
    row_last   = (CNT_W'({ev_row, {WLOG{1'b1}}}) + CNT_W'(1)) >= n;
    pop        = CNT_W'($countones(empty));
    found_next = CNT_W'(found) + CNT_W'(1);
    alloc_off  = AW'(HEADER_BYTES) + AW'(n) + (AW'(found) << lg);
    free_bit   = row_data[free_idx[WLOG-1:0]];
    cnt_total  = cnt_acc + pop;
    last_total = any_empty ? hi_idx : last_acc;
    has_total  = any_empty || has_acc;
  end

  // End of command and bitmap write
  always_comb begin
    wr_en   = 1'b0;
    wr_data = row_data;
    case (cmd_q)
      CMD_ALLOC: begin
        stat.last = any_cand || row_last;
        if (ctl.finish && any_cand) begin
          wr_en   = 1'b1;
          wr_data = row_data | low_iso;
        end
      end
      CMD_FREE: begin
        stat.last = 1'b1;
        if (ctl.finish && !free_bad && free_bit) begin
          wr_en   = 1'b1;
          wr_data = row_data & ~(W'(1) << free_idx[WLOG-1:0]);
        end
      end
      CMD_COUNT: stat.last = row_last;
      default:   stat.last = 1'b1;
    endcase
  end

  // Bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ev_row] <= wr_data;
    end
    rdata  <= mem[rd_row];
    ev_row <= rd_row;
  end

  // Row valid bits: unwritten rows read as all empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[ev_row] <= 1'b1;
      end
      rvalid_q <= row_valid[rd_row];
    end
  end

  // Config and hint
  always_ff @(posedge clk) begin
    if (rst) begin
      lg   <= LG_RESET;
      n    <= CNT_W'(N_RESET);
      hint <= '0;
    end else begin
      if (cfg_we) begin
        lg <= cfg_wdata;
        n  <= n_next;
      end
      if (ctl.finish) begin
        case (cmd_q)
          CMD_ALLOC: begin
            if (any_cand) begin
              hint <= (found_next == n) ? '0 : found_next[IDX_W-1:0];
            end else begin
              hint <= '0;
            end
          end
          CMD_COUNT: begin
            if (has_total) begin
              hint <= last_total;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Item registers, row address and count accumulation
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q    <= cmd_t'(cmd);
      free_idx <= idx_full[IDX_W-1:0];
      free_bad <= bad_in;
      rd_row   <= first_row;
      cnt_acc  <= '0;
      last_acc <= '0;
      has_acc  <= 1'b0;
    end else begin
      if (ctl.step) begin
        rd_row <= rd_row + ROW_W'(1);
      end
      if (ctl.eval && !ctl.finish && cmd_q == CMD_COUNT) begin
        cnt_acc  <= cnt_total;
        last_acc <= last_total;
        has_acc  <= has_total;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      status       <= ST_OK;
      block_offset <= '0;
      blk_index    <= '0;
      empty_count  <= '0;
      case (cmd_q)
        CMD_ALLOC: begin
          if (any_cand) begin
            block_offset <= OFF_W'(alloc_off);
            blk_index    <= IDX_O_W'(found);
          end else begin
            status <= ST_FULL;
          end
        end
        CMD_FREE: begin
          if (free_bad) begin
            status <= ST_RANGE;
          end else begin
            blk_index <= IDX_O_W'(free_idx);
            if (!free_bit) begin
              status <= ST_EMPTY;
            end
          end
        end
        CMD_COUNT: begin
          empty_count <= CNT_O_W'(cnt_total);
        end
        default: begin
        end
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_write_at_finish: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (ctl.finish && ctl.eval))
    else $error("bitmap written outside the final row evaluation");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (row_valid == '0 && hint == '0 && !done))
    else $error("allocator state not cleared by reset");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import pal_pkg::*;

  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned HEADER_BYTES = 64;
  localparam int unsigned BLOCK_CAP    = 2048;

  typedef struct {
    cmd_t             op;
    logic [OFF_W-1:0] off;
  } page_cmd_t;

  typedef struct {
    status_t            status;
    logic [OFF_W-1:0]   offset;
    logic [IDX_O_W-1:0] index;
    logic [CNT_O_W-1:0] count;
  } page_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [CMD_W-1:0]    cmd = CMD_ALLOC;
  logic [OFF_W-1:0]    free_offset = '0;
  logic                cfg_we = 1'b0;
  logic [LG_W-1:0]     cfg_wdata = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    block_offset;
  logic [IDX_O_W-1:0]  blk_index;
  logic [CNT_O_W-1:0]  empty_count;

  // Shadow of the allocator: occupancy bitmap, search hint, block size
  logic [BLOCK_CAP-1:0] occ = '0;
  logic [IDX_O_W-1:0]   hint = '0;
  logic [LG_W-1:0]      size_lg = LG_RESET;

  page_cmd_t    cmd_q[$];
  page_result_t expected_results[$];
  int unsigned  gap_left = 0;
  logic         no_gaps = 1'b0;
  int unsigned  mismatches = 0;

  page_block_allocator_top #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .BLOCK_CAP   (BLOCK_CAP)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .free_offset (free_offset),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .status      (status),
    .block_offset(block_offset),
    .blk_index   (blk_index),
    .empty_count (empty_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned blocks_for(logic [LG_W-1:0] lg);
    int unsigned n;
    n = (PAGE_BYTES - HEADER_BYTES) / ((32'd1 << lg) + 1);
    if (n > BLOCK_CAP) n = BLOCK_CAP;
    return n;
  endfunction

  // Expected result of one command; updates the shadow bitmap and hint
  function automatic page_result_t predict_alloc_result(cmd_t op, logic [OFF_W-1:0] off);
    int unsigned n, base, found, idx, cnt, i, pos;
    page_result_t r;
    n = blocks_for(size_lg);
    base = HEADER_BYTES + n;
    r.status = ST_OK;
    r.offset = '0;
    r.index = '0;
    r.count = '0;
    cnt = 0;
    case (op)
      CMD_ALLOC: begin
        // forward scan from the hint, no wrap
        found = n;
        for (i = hint; i < n && found == n; i++)
          if (!occ[i]) found = i;
        if (found < n) begin
          occ[found] = 1'b1;
          pos = base + (found << size_lg);
          r.offset = pos[OFF_W-1:0];
          r.index = found[IDX_O_W-1:0];
          pos = found + 1;
          hint = (pos == n) ? '0 : pos[IDX_O_W-1:0];
        end else begin
          r.status = ST_FULL;
          hint = '0;
        end
      end
      CMD_FREE: begin
        if (off < base) begin
          r.status = ST_RANGE;
        end else begin
          idx = (off - base) >> size_lg;
          if (idx >= n) begin
            r.status = ST_RANGE;
          end else begin
            r.index = idx[IDX_O_W-1:0];
            if (!occ[idx]) r.status = ST_EMPTY;
            else occ[idx] = 1'b0;
          end
        end
      end
      CMD_COUNT: begin
        // hint ends on the highest empty block
        for (i = 0; i < n; i++)
          if (!occ[i]) begin
            cnt++;
            hint = i[IDX_O_W-1:0];
          end
        r.count = cnt[CNT_O_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (want !== got)
      flag($sformatf("%s: expected %0d, got %0d", name, want, got));
  endfunction

  // Command driver: predicts each item as it is accepted
  always @(posedge clk) begin
    page_cmd_t   cur;
    int unsigned gap;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      cur = cmd_q.pop_front();
      expected_results.push_back(predict_alloc_result(cur.op, cur.off));
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap == 0 && cmd_q.size() != 0) begin
        cmd <= cmd_q[0].op;
        free_offset <= cmd_q[0].off;
      end else begin
        start <= 1'b0;
      end
      gap_left <= gap;
    end else if (!start) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() != 0) begin
        start <= 1'b1;
        cmd <= cmd_q[0].op;
        free_offset <= cmd_q[0].off;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    page_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        flag($sformatf("unexpected result: status %0d offset %0d index %0d count %0d",
                       status, block_offset, blk_index, empty_count));
      end else begin
        want = expected_results.pop_front();
        check_field("status", 12'(want.status), 12'(status));
        check_field("block_offset", want.offset, block_offset);
        check_field("blk_index", 12'(want.index), 12'(blk_index));
        check_field("empty_count", want.count, empty_count);
      end
    end
  end

  task automatic queue_cmd(cmd_t op, int unsigned off);
    page_cmd_t c;
    c.op = op;
    c.off = off[OFF_W-1:0];
    cmd_q.push_back(c);
  endtask

  // Wait until every item is accepted and every result is back
  task automatic drain();
    while (cmd_q.size() != 0 || expected_results.size() != 0 || start || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [LG_W-1:0] lg);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lg;
    size_lg = lg;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly allocs and frees of blocks likely in use, some noise
  task automatic fill_random(logic [LG_W-1:0] lg, int unsigned nitems);
    int unsigned n, base, k, pick, idx, span, allocs, off;
    n = blocks_for(lg);
    base = HEADER_BYTES + n;
    allocs = 0;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (k = 0; k < nitems; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_cmd(CMD_ALLOC, $urandom);
        allocs++;
      end else if (pick < 80 && n != 0) begin
        span = (2 * allocs + 4 < n) ? 2 * allocs + 4 : n;
        idx = $urandom_range(0, span - 1);
        off = base + (idx << lg) + $urandom_range(0, (32'd1 << lg) - 1);
        queue_cmd(CMD_FREE, off);
      end else if (pick < 87) begin
        queue_cmd(CMD_FREE, $urandom_range(0, 4095));
      end else if (pick < 97) begin
        queue_cmd(CMD_COUNT, $urandom);
      end else begin
        queue_cmd(CMD_NONE, $urandom);
      end
    end
  endtask

  initial begin
    logic [LG_W-1:0] sizes[$];
    sizes = '{4'd3, 4'd0, 4'd7, 4'd9, 4'd10, 4'd11, 4'd8, 4'd5, 4'd12,
              4'd6, 4'd4, 4'd2, 4'd1, 4'd13, 4'd14, 4'd15, 4'd3};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // 8-byte blocks after reset: 448 blocks, data area at 512
    queue_cmd(CMD_COUNT, 0);
    queue_cmd(CMD_ALLOC, 0);        // hint at the last block
    queue_cmd(CMD_ALLOC, 4095);
    queue_cmd(CMD_ALLOC, 0);
    queue_cmd(CMD_ALLOC, 0);
    queue_cmd(CMD_FREE, 0);         // below the data area
    queue_cmd(CMD_FREE, 511);
    queue_cmd(CMD_FREE, 525);       // unaligned, truncated to block 1
    queue_cmd(CMD_FREE, 520);       // block 1 already empty
    queue_cmd(CMD_FREE, 4095);
    queue_cmd(CMD_NONE, 4095);
    queue_cmd(CMD_ALLOC, 0);
    drain();

    // 1-byte blocks: most blocks, top offset
    write_size(4'd0);
    queue_cmd(CMD_COUNT, 0);
    queue_cmd(CMD_ALLOC, 0);
    queue_cmd(CMD_FREE, 4095);
    queue_cmd(CMD_FREE, 2079);
    queue_cmd(CMD_COUNT, 0);        // leaves the hint high
    drain();

    // one block: hint now past the block count
    write_size(4'd11);
    queue_cmd(CMD_ALLOC, 0);
    queue_cmd(CMD_ALLOC, 0);
    queue_cmd(CMD_FREE, 165);
    queue_cmd(CMD_ALLOC, 0);
    queue_cmd(CMD_FREE, 4095);      // past the last block
    queue_cmd(CMD_FREE, 64);
    drain();

    // no blocks at all
    write_size(4'd15);
    queue_cmd(CMD_ALLOC, 0);
    queue_cmd(CMD_FREE, 4095);
    queue_cmd(CMD_COUNT, 0);
    drain();

    foreach (sizes[p]) begin
      write_size(sizes[p]);
      fill_random(sizes[p], 24);
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pal_pkg.sv
hdl/pal_ctrl.sv
hdl/pal_datapath.sv
hdl/page_block_allocator_top.sv
test/tb.sv
